@@ hw/rtl/spi_pkg.sv @@
// ----------------------------------------------------------------------------
// spi_pkg
// shared types, constants and point index tables for the segment pair test
// ----------------------------------------------------------------------------
package spi_pkg;

    // default coordinate width, range 4 to 30
    localparam int COORD_BITS_DEF = 16;

    localparam int REL_BITS = 2;

    typedef enum logic [REL_BITS-1:0] {
        REL_OUT = 2'd0,
        REL_ON  = 2'd1,
        REL_IN  = 2'd2
    } t_relation;

    // point slots: a start, a end, b start, b end
    typedef logic [1:0] t_pt;

    localparam t_pt PT_A1 = 2'd0;
    localparam t_pt PT_A2 = 2'd1;
    localparam t_pt PT_B1 = 2'd2;
    localparam t_pt PT_B2 = 2'd3;

    localparam int N_DET = 4;

    // orientation of triangle (a, b, c), one row per determinant
    localparam t_pt ORIENT_A [N_DET] = '{PT_A1, PT_A1, PT_B1, PT_B1};
    localparam t_pt ORIENT_B [N_DET] = '{PT_A2, PT_A2, PT_B2, PT_B2};
    localparam t_pt ORIENT_C [N_DET] = '{PT_B1, PT_B2, PT_A1, PT_A2};

endpackage

@@ hw/rtl/spi_decide.sv @@
// ----------------------------------------------------------------------------
// spi_decide
// forms determinants and projections from partial products and classifies
// ----------------------------------------------------------------------------
module spi_decide #(
    parameter int PW = 34
) (
    input  logic signed [PW-1:0] i_pa [spi_pkg::N_DET],
    input  logic signed [PW-1:0] i_pb [spi_pkg::N_DET],
    input  logic signed [PW-1:0] i_qa [spi_pkg::N_DET],
    input  logic signed [PW-1:0] i_qb [spi_pkg::N_DET],
    output spi_pkg::t_relation   o_relation
);

    localparam int SW = PW + 1;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_side;

    logic signed [SW-1:0] det  [spi_pkg::N_DET];
    logic signed [SW-1:0] proj [spi_pkg::N_DET];
    t_side                side [spi_pkg::N_DET];

    logic ss_a, ss_b, any_zero, colinear, overlap;

    always_comb begin
        for (int k = 0; k < spi_pkg::N_DET; k++) begin
            det[k]       = SW'(i_pa[k]) - SW'(i_pb[k]);
            proj[k]      = SW'(i_qa[k]) + SW'(i_qb[k]);
            side[k].neg  = det[k][SW-1];
            side[k].zero = (det[k] == '0);
        end
    end

    // strict same side: both positive or both negative
    function automatic logic same_side(input t_side u, input t_side v);
        logic pu, pv;
        pu = !u.neg && !u.zero;
        pv = !v.neg && !v.zero;
        return (pu && pv) || (u.neg && v.neg);
    endfunction

    always_comb begin
        ss_a     = same_side(side[0], side[1]);
        ss_b     = same_side(side[2], side[3]);
        any_zero = side[0].zero || side[1].zero || side[2].zero || side[3].zero;
        colinear = (side[0].zero && side[1].zero) || (side[2].zero && side[3].zero);
        // projected interval overlap along a
        overlap  = (proj[0] <= proj[2] && proj[2] <= proj[1])
                || (proj[0] <= proj[3] && proj[3] <= proj[1])
                || (proj[2] <= proj[3] && proj[2] <= proj[0] && proj[1] <= proj[3])
                || (proj[3] <= proj[2] && proj[3] <= proj[0] && proj[1] <= proj[2]);

        priority if (ss_a || ss_b) begin
            o_relation = spi_pkg::REL_OUT;
        end else if (!any_zero) begin
            o_relation = spi_pkg::REL_IN;
        end else if (!colinear) begin
            o_relation = spi_pkg::REL_ON;
        end else if (overlap) begin
            o_relation = spi_pkg::REL_ON;
        end else begin
            o_relation = spi_pkg::REL_OUT;
        end
    end

endmodule

@@ hw/rtl/segment_pair_intersect_2d.sv @@
// ----------------------------------------------------------------------------
// segment_pair_intersect_2d
// exact 2d segment pair classification: out, on (touching) or in (crossing)
// ----------------------------------------------------------------------------
// usage:
//   drive the eight endpoint coordinates and raise start; a word is taken at
//   each rising edge with start high and busy low. busy is high only while
//   reset is applied and for the first cycle after it.
//   o_valid pulses for one cycle with o_relation: 0 out, 1 on, 2 in.
// pipeline: an accepted word passes the input register, the product
//   register and the result register before o_valid rises.
// throughput: one word per cycle while busy is low, back to back, with no gaps.
//   the path that sets the clock is the product stage: one coordinate
//   difference feeding a (COORD_BITS+1) square signed multiplier.
// reset: synchronous, clears the pipeline valid bits; words in flight are
//   dropped and no strobe follows them.
// the receiver cannot stall: each result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
module segment_pair_intersect_2d #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_a_start_x,
    input  logic signed [COORD_BITS-1:0] i_a_start_y,
    input  logic signed [COORD_BITS-1:0] i_a_end_x,
    input  logic signed [COORD_BITS-1:0] i_a_end_y,
    input  logic signed [COORD_BITS-1:0] i_b_start_x,
    input  logic signed [COORD_BITS-1:0] i_b_start_y,
    input  logic signed [COORD_BITS-1:0] i_b_end_x,
    input  logic signed [COORD_BITS-1:0] i_b_end_y,
    output logic                         o_valid,
    output logic [spi_pkg::REL_BITS-1:0] o_relation
);

    // extended coordinate and product widths
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    localparam int NP = 4;

    logic accept;

    // control
    logic r_busy;
    logic r_v_in, r_v_prod, r_v_out;

    // stage 1: captured endpoints
    logic signed [COORD_BITS-1:0] r_px [NP];
    logic signed [COORD_BITS-1:0] r_py [NP];

    // stage 2: partial products
    logic signed [DW-1:0] ex [NP];
    logic signed [DW-1:0] ey [NP];
    logic signed [DW-1:0] dx, dy;
    logic signed [PW-1:0] n_pa [spi_pkg::N_DET];
    logic signed [PW-1:0] n_pb [spi_pkg::N_DET];
    logic signed [PW-1:0] n_qa [spi_pkg::N_DET];
    logic signed [PW-1:0] n_qb [spi_pkg::N_DET];
    logic signed [PW-1:0] r_pa [spi_pkg::N_DET];
    logic signed [PW-1:0] r_pb [spi_pkg::N_DET];
    logic signed [PW-1:0] r_qa [spi_pkg::N_DET];
    logic signed [PW-1:0] r_qb [spi_pkg::N_DET];

    // stage 3: result
    spi_pkg::t_relation n_relation;
    spi_pkg::t_relation r_relation;

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    // control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_v_in   <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_v_in   <= accept;
            r_v_prod <= r_v_in;
            r_v_out  <= r_v_prod;
        end
    end

    // input register, loaded on every accepted word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px[spi_pkg::PT_A1] <= i_a_start_x;
            r_py[spi_pkg::PT_A1] <= i_a_start_y;
            r_px[spi_pkg::PT_A2] <= i_a_end_x;
            r_py[spi_pkg::PT_A2] <= i_a_end_y;
            r_px[spi_pkg::PT_B1] <= i_b_start_x;
            r_py[spi_pkg::PT_B1] <= i_b_start_y;
            r_px[spi_pkg::PT_B2] <= i_b_end_x;
            r_py[spi_pkg::PT_B2] <= i_b_end_y;
        end
    end

    // orientation: (ax - cx) * (by - cy) - (ay - cy) * (bx - cx)
    // projection onto a: x * dx + y * dy
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            ex[p] = DW'(r_px[p]);
            ey[p] = DW'(r_py[p]);
        end
        dx = ex[spi_pkg::PT_A2] - ex[spi_pkg::PT_A1];
        dy = ey[spi_pkg::PT_A2] - ey[spi_pkg::PT_A1];
        for (int k = 0; k < spi_pkg::N_DET; k++) begin
            n_pa[k] = PW'(ex[spi_pkg::ORIENT_A[k]] - ex[spi_pkg::ORIENT_C[k]])
                    * PW'(ey[spi_pkg::ORIENT_B[k]] - ey[spi_pkg::ORIENT_C[k]]);
            n_pb[k] = PW'(ey[spi_pkg::ORIENT_A[k]] - ey[spi_pkg::ORIENT_C[k]])
                    * PW'(ex[spi_pkg::ORIENT_B[k]] - ex[spi_pkg::ORIENT_C[k]]);
            n_qa[k] = PW'(ex[k]) * PW'(dx);
            n_qb[k] = PW'(ey[k]) * PW'(dy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v_in) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_qa <= n_qa;
            r_qb <= n_qb;
        end
    end

    // determinant signs, colinear overlap and final decision
    spi_decide #(
        .PW (PW)
    ) u_decide (
        .i_pa       (r_pa),
        .i_pb       (r_pb),
        .i_qa       (r_qa),
        .i_qb       (r_qb),
        .o_relation (n_relation)
    );

    always_ff @(posedge i_clk) begin
        if (r_v_prod) begin
            r_relation <= n_relation;
        end
    end

    assign o_valid    = r_v_out;
    assign o_relation = r_relation;

`ifndef SYNTHESIS
    // every accepted word comes out with a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("accepted word produced no result");

    // no strobe without an accepted word before it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 3))
        else $error("result strobe without an accepted word");

    // the unused code never leaves the block
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_relation == spi_pkg::REL_OUT || o_relation == spi_pkg::REL_ON
                     || o_relation == spi_pkg::REL_IN))
        else $error("invalid relation code");
`endif

endmodule
